// ===== rtl/srtf_pkg.sv =====
package srtf_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int TIME_W    = 16;
	localparam int REM_W     = 16;
	localparam int CFG_W     = 5;
	localparam int ACT_W     = 3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_START     = 3'd0,
		ACT_RESUME    = 3'd1,
		ACT_SUSPEND   = 3'd2,
		ACT_TERMINATE = 3'd3,
		ACT_DONE      = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		K_TERM = 2'd0,
		K_DONE = 2'd1,
		K_SUSP = 2'd2,
		K_SEL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic term;
		logic done;
		logic susp;
		logic sel;
	} emit_flags_t;

	typedef struct packed {
		logic  load;
		logic  tick;
		logic  dec;
		logic  scan_clr;
		logic  scan_issue;
		logic  decide;
		logic  emit;
		kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic        scan_end;
		emit_flags_t em;
		logic        out_free;
	} sts_t;

endpackage

// ===== rtl/srtf_if.sv =====
interface srtf_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [srtf_pkg::SLOT_W-1:0] slot;
	logic [srtf_pkg::TIME_W-1:0] arrival_time;
	logic [srtf_pkg::REM_W-1:0]  burst_time;

	modport source (output valid, opcode, slot, arrival_time, burst_time, input ready);
	modport sink (input valid, opcode, slot, arrival_time, burst_time, output ready);
endinterface

interface srtf_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [srtf_pkg::ACT_W-1:0]  action;
	logic [srtf_pkg::SLOT_W-1:0] target_slot;
	logic [srtf_pkg::REM_W-1:0]  remaining;
	logic [srtf_pkg::TIME_W-1:0] time_now;
	logic                        last;

	modport source (output valid, action, target_slot, remaining, time_now, last, input ready);
	modport sink (input valid, action, target_slot, remaining, time_now, last, output ready);
endinterface

interface srtf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [srtf_pkg::CFG_W-1:0] process_count;

	modport source (output valid, process_count, input ready);
	modport sink (input valid, process_count, output ready);
endinterface

// ===== rtl/srtf_ctrl.sv =====
module srtf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_opcode,
	output logic             in_ready,
	input  srtf_pkg::sts_t   sts,
	output srtf_pkg::cmd_t   cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DEC    = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_TERM   = 8'b0001_0000,
		S_DONE   = 8'b0010_0000,
		S_SUSP   = 8'b0100_0000,
		S_SEL    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.kind = srtf_pkg::K_TERM;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == srtf_pkg::OP_TICK) begin
						cmd.tick = 1'b1;
						state_d  = S_DEC;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_DEC: begin
				cmd.dec      = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.scan_issue = 1'b1;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_TERM;
			end
			S_TERM: begin
				cmd.kind = srtf_pkg::K_TERM;
				if (!sts.em.term) begin
					state_d = S_DONE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				cmd.kind = srtf_pkg::K_DONE;
				if (!sts.em.done) begin
					state_d = S_SUSP;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_SUSP;
				end
			end
			S_SUSP: begin
				cmd.kind = srtf_pkg::K_SUSP;
				if (!sts.em.susp) begin
					state_d = S_SEL;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_SEL;
				end
			end
			S_SEL: begin
				cmd.kind = srtf_pkg::K_SEL;
				if (!sts.em.sel) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/srtf_dp.sv =====
module srtf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  srtf_pkg::cmd_t              cmd,
	output srtf_pkg::sts_t              sts,
	input  logic [srtf_pkg::SLOT_W-1:0] slot,
	input  logic [srtf_pkg::TIME_W-1:0] arrival_time,
	input  logic [srtf_pkg::REM_W-1:0]  burst_time,
	srtf_cfg_if.sink                    cfg,
	srtf_rsp_if.source                  rsp
);

	logic [srtf_pkg::TIME_W-1:0] arr_mem [srtf_pkg::MAX_SLOTS];
	logic [srtf_pkg::REM_W-1:0]  rem_mem [srtf_pkg::MAX_SLOTS];
	logic [srtf_pkg::MAX_SLOTS-1:0] started_q;

	logic [srtf_pkg::SLOT_W-1:0] run_slot_q;
	logic                        run_valid_q;
	logic [srtf_pkg::REM_W-1:0]  run_rem_q;
	logic [srtf_pkg::TIME_W-1:0] tick_q;
	logic [srtf_pkg::CNT_W-1:0]  count_q;
	logic [srtf_pkg::CNT_W-1:0]  idx_q;

	logic [srtf_pkg::SLOT_W-1:0] rd_addr;
	logic [srtf_pkg::REM_W-1:0]  rd_rem_q;
	logic [srtf_pkg::TIME_W-1:0] rd_arr_q;
	logic                        cmp_v_s1;
	logic [srtf_pkg::SLOT_W-1:0] cmp_slot_s1;

	logic                        best_v_q;
	logic [srtf_pkg::SLOT_W-1:0] best_slot_q;
	logic [srtf_pkg::REM_W-1:0]  best_rem_q;
	logic                        work_q;
	srtf_pkg::emit_flags_t       em_q;

	logic [srtf_pkg::REM_W-1:0]  dec_rem;
	logic                        term_now;
	logic                        better;
	logic                        out_free;

	logic                        out_valid_q;
	srtf_pkg::act_t              out_act_q;
	logic [srtf_pkg::SLOT_W-1:0] out_slot_q;
	logic [srtf_pkg::REM_W-1:0]  out_rem_q;
	logic [srtf_pkg::TIME_W-1:0] out_time_q;
	logic                        out_last_q;

	assign dec_rem  = (rd_rem_q == '0) ? '0 : rd_rem_q - 1'b1;
	assign term_now = run_valid_q && (dec_rem == '0);
	assign rd_addr  = cmd.scan_issue ? idx_q[srtf_pkg::SLOT_W-1:0] : run_slot_q;
	assign better   = cmp_v_s1 && (rd_rem_q != '0) && (rd_arr_q <= tick_q) &&
		(!best_v_q || (rd_rem_q < best_rem_q));
	assign out_free = !out_valid_q || rsp.ready;

	assign sts.scan_end = (idx_q == count_q);
	assign sts.em       = em_q;
	assign sts.out_free = out_free;

	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.action      = out_act_q;
	assign rsp.target_slot = out_slot_q;
	assign rsp.remaining   = out_rem_q;
	assign rsp.time_now    = out_time_q;
	assign rsp.last        = out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			arr_mem[slot] <= arrival_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srtf_pkg::MAX_SLOTS; i++) begin
				rem_mem[i] <= '0;
			end
		end else if (cmd.load) begin
			rem_mem[slot] <= burst_time;
		end else if (cmd.dec && run_valid_q) begin
			rem_mem[run_slot_q] <= dec_rem;
		end
	end

	always_ff @(posedge clk) begin
		rd_rem_q    <= rem_mem[rd_addr];
		rd_arr_q    <= arr_mem[rd_addr];
		cmp_slot_s1 <= idx_q[srtf_pkg::SLOT_W-1:0];
		if (cmd.dec) begin
			run_rem_q <= dec_rem;
		end
		if (better) begin
			best_slot_q <= cmp_slot_s1;
			best_rem_q  <= rd_rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= srtf_pkg::CNT_W'(1);
			tick_q      <= '0;
			idx_q       <= '0;
			cmp_v_s1    <= 1'b0;
			best_v_q    <= 1'b0;
			work_q      <= 1'b0;
			em_q        <= '0;
			started_q   <= '0;
			run_slot_q  <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (int'(cfg.process_count) > srtf_pkg::MAX_SLOTS) begin
					count_q <= srtf_pkg::CNT_W'(srtf_pkg::MAX_SLOTS);
				end else begin
					count_q <= srtf_pkg::CNT_W'(cfg.process_count);
				end
			end
			if (cmd.tick && (tick_q != '1)) begin
				tick_q <= tick_q + 1'b1;
			end
			cmp_v_s1 <= cmd.scan_issue;
			if (cmd.scan_clr) begin
				idx_q    <= '0;
				best_v_q <= 1'b0;
				work_q   <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmp_v_s1 && (rd_rem_q != '0)) begin
					work_q <= 1'b1;
				end
				if (better) begin
					best_v_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				started_q[slot] <= 1'b0;
				if (run_valid_q && (run_slot_q == slot)) begin
					run_valid_q <= 1'b0;
				end
			end
			if (cmd.dec) begin
				em_q <= '{term: term_now, done: 1'b0, susp: 1'b0, sel: 1'b0};
				if (term_now) begin
					started_q[run_slot_q] <= 1'b0;
					run_valid_q           <= 1'b0;
				end
			end
			if (cmd.decide) begin
				em_q.done <= !work_q;
				em_q.susp <= work_q && run_valid_q &&
					(!best_v_q || (run_slot_q != best_slot_q));
				em_q.sel  <= work_q && best_v_q &&
					(!run_valid_q || (run_slot_q != best_slot_q));
			end
			if (cmd.emit && (cmd.kind == srtf_pkg::K_SUSP)) begin
				run_valid_q <= 1'b0;
			end
			if (cmd.emit && (cmd.kind == srtf_pkg::K_SEL)) begin
				started_q[best_slot_q] <= 1'b1;
				run_slot_q             <= best_slot_q;
				run_valid_q            <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_time_q <= tick_q;
			case (cmd.kind)
				srtf_pkg::K_TERM: begin
					out_act_q  <= srtf_pkg::ACT_TERMINATE;
					out_slot_q <= run_slot_q;
					out_rem_q  <= '0;
					out_last_q <= !(em_q.done || em_q.sel);
				end
				srtf_pkg::K_DONE: begin
					out_act_q  <= srtf_pkg::ACT_DONE;
					out_slot_q <= '0;
					out_rem_q  <= '0;
					out_last_q <= 1'b1;
				end
				srtf_pkg::K_SUSP: begin
					out_act_q  <= srtf_pkg::ACT_SUSPEND;
					out_slot_q <= run_slot_q;
					out_rem_q  <= run_rem_q;
					out_last_q <= !em_q.sel;
				end
				srtf_pkg::K_SEL: begin
					out_act_q  <= started_q[best_slot_q] ? srtf_pkg::ACT_RESUME
						: srtf_pkg::ACT_START;
					out_slot_q <= best_slot_q;
					out_rem_q  <= best_rem_q;
					out_last_q <= 1'b1;
				end
				default: begin
					out_act_q  <= srtf_pkg::ACT_DONE;
					out_slot_q <= '0;
					out_rem_q  <= '0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	a_run_started: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> started_q[run_slot_q])
		else $error("running slot not marked started");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("item emitted into a full output register");

	a_sel_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && (cmd.kind == srtf_pkg::K_SEL)) |-> best_v_q)
		else $error("dispatch without a picked slot");

	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && (tick_q != '1)) |=> (tick_q == srtf_pkg::TIME_W'($past(tick_q) + 1'b1)))
		else $error("tick count did not advance");

endmodule

// ===== rtl/srtf_tick_scheduler_unit.sv =====
// Load item: taken in idle, no result.
// Tick item: decrement, scan of N slots (N = process_count capped at 16), decide and emit steps,
// all before the next accept; an emit waits on rsp.ready, the scan reads one slot per cycle.
// Up to two result items per tick through one output register; one item at a time.
// arst_n clears remaining bursts, started flags, running slot and tick count; arrival
// entries hold no reset value and process_count resets to 1.
module srtf_tick_scheduler_unit (
	input  logic       clk,
	input  logic       arst_n,
	srtf_cfg_if.sink   cfg,
	srtf_req_if.sink   req,
	srtf_rsp_if.source rsp
);

	srtf_pkg::cmd_t cmd;
	srtf_pkg::sts_t sts;

	srtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	srtf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.slot         (req.slot),
		.arrival_time (req.arrival_time),
		.burst_time   (req.burst_time),
		.cfg          (cfg),
		.rsp          (rsp)
	);

endmodule
